// ===== rtl/core/gsd_pkg.sv =====
// Shared types and constants of the Gini / Simpson diversity engine.
// No dependencies; imported by the top-level module and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package gsd_pkg;

  localparam int SIZE_BITS = 11;
  localparam int FRAC_BITS = 16;

  localparam int GINI_W   = 16;
  localparam int SIMP_W   = 17;
  localparam int LARGE_W  = 11;
  localparam int COUNT_W  = 12;
  localparam int TOTAL_W  = 22;
  localparam int STATUS_W = 2;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 80;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/core/gsd_store.sv =====
// Size store: one write port and one read port with registered read data.
// Standalone; instantiated by gini_simpson_diversity_engine.
`timescale 1ns / 1ps
`default_nettype none

module gsd_store #(
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = 11,
  parameter int DATA_W = 11
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [DATA_W-1:0] rd_data_o,
  output logic                   rd_valid_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;
  logic              rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= rd_en_i;
    end
  end

  assign rd_data_o  = rd_data_q;
  assign rd_valid_o = rd_valid_q;

endmodule

`default_nettype wire

// ===== rtl/core/gsd_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by all fractions.
// Standalone; instantiated by gini_simpson_diversity_engine.
`timescale 1ns / 1ps
`default_nettype none

module gsd_div #(
  parameter int NUM_W = 51,
  parameter int DEN_W = 23
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic      [NUM_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  always_comb begin
    trial = {rem_q, num_q[NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    fits  = trial >= {1'b0, den_q};
    rem_d = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    num_d = {num_q[NUM_W-2:0], fits};
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

`default_nettype wire

// ===== rtl/core/gini_simpson_diversity_engine.sv =====
// Top level of the Gini / Simpson diversity engine: control, accumulators, result register.
// Depends on gsd_pkg, gsd_store and gsd_div.
//
//   channel   dir  fields (low bit first)
//   s_axis    in   tdata: size_value[10:0], zero fill; tlast: last_item
//   m_axis    out  tdata: gini_frac, simpson_frac, largest_size, list_count,
//                        list_total, status
//
// An item with n sizes already stored is compared with each of them: the stored sizes are
// read back one per cycle through the single read port of the size store.
// Unless the count or total is zero, the last item of a list adds four serial divisions of
// NUM_W quotient bits each (NUM_W = 51 at the default MAX_ITEMS) before the result loads.
// Reset clears all counters and sums; the store itself is not cleared.
// A waiting result does not block new requests; a second result waits for it.
`timescale 1ns / 1ps
`default_nettype none

module gini_simpson_diversity_engine #(
  parameter int MAX_ITEMS = 2048
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // size_value[10:0], zero fill [15:11]
  input  wire logic [gsd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // last_item
  input  wire logic                            s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // gini_frac[15:0], simpson_frac[32:16], largest_size[43:33],
  // list_count[55:44], list_total[77:56], status[79:78]
  output logic      [gsd_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  import gsd_pkg::*;

  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int ADDR_W = $clog2(MAX_ITEMS);
  localparam int TOT_W  = SIZE_BITS + CNT_W;
  localparam int SQ_W   = 2 * SIZE_BITS + CNT_W;
  localparam int PAIR_W = SIZE_BITS + 2 * CNT_W;
  localparam int NUM_W  = ((PAIR_W > SQ_W) ? PAIR_W : SQ_W) + FRAC_BITS;

  state_e               state_q, state_d;
  logic [SIZE_BITS-1:0] v_q, v_d;
  logic                 last_q, last_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [TOT_W-1:0]     total_q, total_d;
  logic [SQ_W-1:0]      sq_q, sq_d;
  logic [PAIR_W-1:0]    pair_q, pair_d;
  logic [SIZE_BITS-1:0] max_q, max_d;
  logic                 ovf_q, ovf_d;
  logic [ADDR_W-1:0]    addr_q, addr_d;
  logic [1:0]           step_q, step_d;
  logic [NUM_W-1:0]     quot_q, quot_d;
  logic [GINI_W-1:0]    gini_q, gini_d;
  logic                 out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic                 in_fire;
  logic                 rd_en;
  logic                 wr_en;
  logic [SIZE_BITS-1:0] rd_data;
  logic                 rd_valid;
  logic [SIZE_BITS-1:0] abs_diff;
  logic                 div_start;
  logic [NUM_W-1:0]     div_num;
  logic [TOT_W-1:0]     div_den;
  logic                 div_done;
  logic [NUM_W-1:0]     div_quot;
  logic                 no_total;
  status_e              status;
  logic [63:0]          count_ext;
  logic [63:0]          total_ext;

  gsd_store #(
    .DEPTH  (MAX_ITEMS),
    .ADDR_W (ADDR_W),
    .DATA_W (SIZE_BITS)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_addr_i  (count_q[ADDR_W-1:0]),
    .wr_data_i  (v_q),
    .rd_en_i    (rd_en),
    .rd_addr_i  (addr_q),
    .rd_data_o  (rd_data),
    .rd_valid_o (rd_valid)
  );

  gsd_div #(
    .NUM_W (NUM_W),
    .DEN_W (TOT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign rd_en         = (state_q == ST_SCAN);
  assign wr_en         = (state_q == ST_COMMIT);
  assign abs_diff      = (rd_data > v_q) ? (rd_data - v_q) : (v_q - rd_data);
  assign no_total      = (count_q == '0) || (total_q == '0);
  assign count_ext     = 64'(count_q);
  assign total_ext     = 64'(total_q);

  always_comb begin
    if (ovf_q) begin
      status = STAT_OVERFLOW;
    end else if (no_total) begin
      status = STAT_EMPTY;
    end else begin
      status = STAT_OK;
    end
  end

  always_comb begin
    unique case (step_q)
      2'd0: begin
        div_num = NUM_W'(pair_q) << FRAC_BITS;
        div_den = total_q;
      end
      2'd1: begin
        div_num = quot_q;
        div_den = TOT_W'(count_q);
      end
      2'd2: begin
        div_num = NUM_W'(sq_q) << FRAC_BITS;
        div_den = total_q;
      end
      default: begin
        div_num = quot_q;
        div_den = total_q;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    v_d         = v_q;
    last_d      = last_q;
    count_d     = count_q;
    total_d     = total_q;
    sq_d        = sq_q;
    pair_d      = pair_q;
    max_d       = max_q;
    ovf_d       = ovf_q;
    addr_d      = addr_q;
    step_d      = step_q;
    quot_d      = quot_q;
    gini_d      = gini_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    div_start   = 1'b0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (rd_valid) begin
      pair_d = pair_q + PAIR_W'(abs_diff);
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          v_d    = s_axis_tdata[SIZE_BITS-1:0];
          last_d = s_axis_tlast;
          addr_d = '0;
          if (count_q == CNT_W'(MAX_ITEMS)) begin
            ovf_d = 1'b1;
            if (s_axis_tlast) begin
              step_d  = 2'd0;
              state_d = ST_DIV_START;
            end
          end else if (count_q == '0) begin
            state_d = ST_COMMIT;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        addr_d = addr_q + ADDR_W'(1);
        if (CNT_W'(addr_q) + CNT_W'(1) == count_q) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        count_d = count_q + CNT_W'(1);
        total_d = total_q + TOT_W'(v_q);
        sq_d    = sq_q + SQ_W'(v_q) * SQ_W'(v_q);
        if (v_q > max_q) begin
          max_d = v_q;
        end
        if (last_q) begin
          step_d  = 2'd0;
          state_d = ST_DIV_START;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV_START: begin
        if (no_total) begin
          gini_d  = '0;
          quot_d  = '0;
          state_d = ST_EMIT;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          quot_d = div_quot;
          if (step_q == 2'd1) begin
            gini_d = div_quot[GINI_W-1:0];
          end
          if (step_q == 2'd3) begin
            state_d = ST_EMIT;
          end else begin
            step_d  = step_q + 2'd1;
            state_d = ST_DIV_START;
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {status, total_ext[TOTAL_W-1:0], count_ext[COUNT_W-1:0],
                         max_q, quot_q[SIMP_W-1:0], gini_q};
          count_d = '0;
          total_d = '0;
          sq_d    = '0;
          pair_d  = '0;
          max_d   = '0;
          ovf_d   = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      sq_q        <= '0;
      pair_q      <= '0;
      max_q       <= '0;
      ovf_q       <= 1'b0;
      addr_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      total_q     <= total_d;
      sq_q        <= sq_d;
      pair_q      <= pair_d;
      max_q       <= max_d;
      ovf_q       <= ovf_d;
      addr_q      <= addr_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q        <= v_d;
    last_q     <= last_d;
    quot_q     <= quot_d;
    gini_q     <= gini_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// ===== tb/tb_gini_simpson_diversity_engine.sv =====
// Self-checking testbench for gini_simpson_diversity_engine: streams lists of group sizes
// and checks every list summary against a cycle-free model of the list statistics.
// Depends on gsd_pkg and the engine RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb_gini_simpson_diversity_engine;
  import gsd_pkg::*;

  localparam int CAPACITY     = 2048;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 400;
  localparam int HOLD_CYCLES  = 4000;
  localparam int PHASE_ITEMS  = 62;
  localparam logic [SIZE_BITS-1:0] SIZE_MAX = '1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TOTAL_W-1:0]  list_total;
    logic [COUNT_W-1:0]  list_count;
    logic [LARGE_W-1:0]  largest_size;
    logic [SIMP_W-1:0]   simpson_frac;
    logic [GINI_W-1:0]   gini_frac;
  } list_summary_t;

  typedef enum int {
    PACE_FULL,
    PACE_SENDER_IDLE,
    PACE_RECEIVER_STALL,
    PACE_BOTH
  } pace_e;

  class list_stats_model;
    logic [SIZE_BITS-1:0] held_sizes[$];
    longint unsigned      total_acc;
    longint unsigned      square_acc;
    longint unsigned      pair_acc;
    logic [SIZE_BITS-1:0] peak_size;
    bit                   dropped;
    list_summary_t        pending_summaries[$];
    int                   mismatches;
    int                   sizes_taken;
    int                   lists_done;
    int                   status_tally[3];

    function void clear_list();
      held_sizes.delete();
      total_acc  = 0;
      square_acc = 0;
      pair_acc   = 0;
      peak_size  = '0;
      dropped    = 1'b0;
    endfunction

    function void note_size(logic [SIZE_BITS-1:0] size, bit last);
      list_summary_t   s;
      longint unsigned n;
      longint unsigned gini;
      longint unsigned simp;
      sizes_taken++;
      if (held_sizes.size() < CAPACITY) begin
        foreach (held_sizes[k]) begin
          if (held_sizes[k] > size) pair_acc += held_sizes[k] - size;
          else pair_acc += size - held_sizes[k];
        end
        total_acc  += size;
        square_acc += longint'(size) * longint'(size);
        if (size > peak_size) peak_size = size;
        held_sizes.insert(held_sizes.size(), size);
      end else begin
        dropped = 1'b1;
      end
      if (!last) return;
      n    = held_sizes.size();
      gini = 0;
      simp = 0;
      if (n != 0 && total_acc != 0) begin
        gini = (pair_acc << FRAC_BITS) / (n * total_acc);
        simp = ((square_acc << FRAC_BITS) / total_acc) / total_acc;
      end
      if (dropped) s.status = STAT_OVERFLOW;
      else if (n == 0 || total_acc == 0) s.status = STAT_EMPTY;
      else s.status = STAT_OK;
      s.gini_frac    = gini[GINI_W-1:0];
      s.simpson_frac = simp[SIMP_W-1:0];
      s.largest_size = peak_size;
      s.list_count   = n[COUNT_W-1:0];
      s.list_total   = total_acc[TOTAL_W-1:0];
      pending_summaries.insert(pending_summaries.size(), s);
      lists_done++;
      clear_list();
    endfunction

    function void check_field(string field, logic [23:0] want, logic [23:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_summary(logic [OUT_DATA_W-1:0] data);
      list_summary_t got;
      list_summary_t want;
      got = data;
      if (pending_summaries.size() == 0) begin
        $error("summary with no list pending: %h", data);
        mismatches++;
        return;
      end
      want = pending_summaries.pop_front();
      if (want.status < 3) status_tally[want.status]++;
      check_field("gini_frac", 24'(want.gini_frac), 24'(got.gini_frac));
      check_field("simpson_frac", 24'(want.simpson_frac), 24'(got.simpson_frac));
      check_field("largest_size", 24'(want.largest_size), 24'(got.largest_size));
      check_field("list_count", 24'(want.list_count), 24'(got.list_count));
      check_field("list_total", 24'(want.list_total), 24'(got.list_total));
      check_field("status", 24'(want.status), 24'(got.status));
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  list_stats_model stats;
  int              sender_idle_pct;
  int              rx_stall_pct;
  int              rx_hold_left;
  int              cycle_count;

  gini_simpson_diversity_engine #(
    .MAX_ITEMS(CAPACITY)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $error("timeout after %0d cycles", cycle_count);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // hold off the result side for a counted stretch, else stall at random
  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      m_axis_tready = 1'b0;
      rx_hold_left--;
    end else begin
      m_axis_tready = ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) stats.check_summary(m_axis_tdata);
  end

  function automatic logic [SIZE_BITS-1:0] pick_size();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return SIZE_BITS'($urandom_range(SIZE_MAX));
    else if (roll < 60) return SIZE_BITS'($urandom_range(15));
    else if (roll < 75) return $urandom_range(1) ? SIZE_MAX : '0;
    else if (roll < 90) return SIZE_BITS'($urandom_range(SIZE_MAX, SIZE_MAX - 60));
    else return '0;
  endfunction

  task automatic set_pace(input pace_e pace);
    sender_idle_pct = (pace == PACE_SENDER_IDLE) ? 88 : (pace == PACE_BOTH) ? 12 : 0;
    rx_stall_pct    = (pace == PACE_RECEIVER_STALL) ? 88 : (pace == PACE_BOTH) ? 12 : 0;
  endtask

  task automatic send_size(input logic [SIZE_BITS-1:0] size, input bit last);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = IN_DATA_W'(size);
    s_axis_tlast  = last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    stats.note_size(size, last);
  endtask

  task automatic run_lists(input int budget, input int max_len);
    int sent;
    int len;
    bit zeros;
    sent = 0;
    while (sent < budget) begin
      len   = ($urandom_range(9) == 0) ? $urandom_range(max_len, 9) : $urandom_range(8, 1);
      zeros = ($urandom_range(19) == 0);
      for (int k = 0; k < len; k++) send_size(zeros ? SIZE_BITS'(0) : pick_size(), k == len - 1);
      sent += len;
    end
  endtask

  // drop the request line, then pause until every summary is back
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (stats.pending_summaries.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    stats           = new();
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tlast    = 1'b0;
    m_axis_tready   = 1'b0;
    sender_idle_pct = 0;
    rx_stall_pct    = 0;
    rx_hold_left    = 0;
    stats.clear_list();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_pace(PACE_FULL);
    send_size(SIZE_MAX, 1'b1);
    send_size('0, 1'b1);
    for (int k = 0; k < 3; k++) send_size('0, k == 2);
    send_size(SIZE_MAX, 1'b0);
    send_size('0, 1'b1);
    for (int k = 0; k < SIZE_BITS; k++) send_size(SIZE_BITS'(1) << k, k == SIZE_BITS - 1);
    send_size(11'h555, 1'b0);
    send_size(11'h2aa, 1'b1);
    wait_drained();

    rx_hold_left = HOLD_CYCLES;
    for (int j = 0; j < 6; j++) begin
      for (int k = 0; k < 4; k++) send_size(pick_size(), k == 3);
    end
    wait_drained();

    for (int p = PACE_FULL; p <= PACE_BOTH; p++) begin
      set_pace(pace_e'(p));
      run_lists(PHASE_ITEMS, (p == PACE_FULL) ? 40 : 16);
      wait_drained();
    end

    set_pace(PACE_FULL);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Streamed %0d sizes in %0d lists (%0d ok, %0d empty or zero total, %0d overflow),",
             stats.sizes_taken, stats.lists_done, stats.status_tally[STAT_OK],
             stats.status_tally[STAT_EMPTY], stats.status_tally[STAT_OVERFLOW]);
    $display("over four pacing phases and a long result-side hold-off.");
    if (stats.mismatches == 0 && stats.pending_summaries.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
